/* rtl/pfp_pkg.sv */
package pfp_pkg;

   // angles in degrees, 16 fraction bits
   localparam logic signed [27:0] DEG360 = 28'sd23592960;
   localparam logic signed [27:0] DEG180 = 28'sd11796480;
   localparam logic signed [27:0] DEG540 = 28'sd35389440;
   localparam logic signed [24:0] DEG90  = 25'sd5898240;
   localparam logic signed [24:0] DEG180_F = 25'sd11796480;

   // cordic
   localparam int CORDIC_STEPS = 17;
   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [24:0] ATAN_TAB [CORDIC_STEPS] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
      25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
      25'sd3667, 25'sd1833, 25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57
   };
   // reduce, fold, one per step, rounding
   localparam int CORDIC_LAT = CORDIC_STEPS + 3;

   // divider
   localparam int QUO_BITS = 18;
   localparam int NUM_W = 58;
   localparam int DEN_W = 37;
   localparam logic [QUO_BITS-1:0] OUT_LIMIT = 18'd131072;

   // whole pipe: cordic, two rotations, divider prep, divider, output
   localparam int TOTAL_LAT = CORDIC_LAT + 3 + QUO_BITS + 1;

endpackage

/* rtl/pole_figure_projection.sv */
// pole figure projection of one unit scattering vector
//
// input channel (req_): q_x, q_y, q_z in signed Q2.14 and the omega and
// hrot angles in degrees with 16 fraction bits. the vector is turned about
// y by omega+180 and about z by -hrot, then projected stereographically.
// result channel (rsp_): r_td and r_nd in signed Q3.16, saturated to +-2.0.
// one result item for every input item, in order.
//
// the pipe has 42 register stages: 20 stages in the two sine and cosine
// units (wrap, fold, 17 cordic steps, rounding), one for each of the two
// rotations, one for divider setup, 18 in the bit-per-stage divider and
// one output register. an item can be taken every cycle while req_stall
// is low.
//
// reset (synchronous, active high) empties the pipe; no item is in flight
// afterwards. the whole pipe moves as one: while a result sits in the output
// register with rsp_stall high, req_stall is high and nothing advances, so
// no item is dropped or repeated.
module pole_figure_projection (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_q_x,
   input  logic signed [15:0]  req_q_y,
   input  logic signed [15:0]  req_q_z,
   input  logic signed [25:0]  req_omega_angle,
   input  logic signed [25:0]  req_hrot_angle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [18:0]  rsp_r_td,
   output logic signed [18:0]  rsp_r_nd
);

   localparam int LAT = pfp_pkg::TOTAL_LAT;
   localparam int CL  = pfp_pkg::CORDIC_LAT;
   localparam int QB  = pfp_pkg::QUO_BITS;

   logic adv;
   logic valid_ff [LAT];

   // pipe moves when the output slot is empty or being taken
   assign adv       = !valid_ff[LAT-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // sine and cosine of both angles
   logic signed [26:0] ang_a, ang_b;
   logic signed [18:0] ca, sa, cb, sb;

   assign ang_a = 27'(req_omega_angle) + 27'sd11796480;
   assign ang_b = -27'(req_hrot_angle);

   pfp_cordic u_cordic_a (
      .clock   (clock),
      .en      (adv),
      .angle   (ang_a),
      .cos_q16 (ca),
      .sin_q16 (sa)
   );

   pfp_cordic u_cordic_b (
      .clock   (clock),
      .en      (adv),
      .angle   (ang_b),
      .cos_q16 (cb),
      .sin_q16 (sb)
   );

   // vector rides along with the cordic
   logic signed [15:0] qx_ff [CL];
   logic signed [15:0] qy_ff [CL];
   logic signed [15:0] qz_ff [CL];

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff[0] <= req_q_x;
         qy_ff[0] <= req_q_y;
         qz_ff[0] <= req_q_z;
         for (int i = 1; i < CL; i++) begin
            qx_ff[i] <= qx_ff[i-1];
            qy_ff[i] <= qy_ff[i-1];
            qz_ff[i] <= qz_ff[i-1];
         end
      end
   end

   // first rotation, about y, Q30
   logic signed [35:0] px_c, pz_s, pz_c, px_s;
   logic signed [35:0] x1_ff, x1_in, y1_ff, y1_in, z1_ff, z1_in;
   logic signed [18:0] cb1_ff, sb1_ff;

   always_comb begin
      px_c  = 36'(qx_ff[CL-1]) * 36'(ca);
      pz_s  = 36'(qz_ff[CL-1]) * 36'(sa);
      pz_c  = 36'(qz_ff[CL-1]) * 36'(ca);
      px_s  = 36'(qx_ff[CL-1]) * 36'(sa);
      x1_in = px_c + pz_s;
      z1_in = pz_c - px_s;
      y1_in = 36'(qy_ff[CL-1]) <<< 16;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= x1_in;
         y1_ff  <= y1_in;
         z1_ff  <= z1_in;
         cb1_ff <= cb;
         sb1_ff <= sb;
      end
   end

   // second rotation, about z, Q46; hemisphere pick and denominator
   logic signed [55:0] x2_ff, x2_in, y2_ff, y2_in;
   logic signed [55:0] t_xc, t_ys, t_yc, t_xs;
   logic               sneg_ff;
   logic [pfp_pkg::DEN_W-1:0] den_ff, den_in;
   logic signed [35:0] z1_abs;

   always_comb begin
      t_xc   = 56'(x1_ff) * 56'(cb1_ff);
      t_ys   = 56'(y1_ff) * 56'(sb1_ff);
      t_yc   = 56'(y1_ff) * 56'(cb1_ff);
      t_xs   = 56'(x1_ff) * 56'(sb1_ff);
      x2_in  = t_xc - t_ys;
      y2_in  = t_yc + t_xs;
      z1_abs = z1_ff[35] ? -z1_ff : z1_ff;
      den_in = (pfp_pkg::DEN_W'(1) << 30) + pfp_pkg::DEN_W'(unsigned'(z1_abs));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff   <= x2_in;
         y2_ff   <= y2_in;
         sneg_ff <= z1_ff[35];
         den_ff  <= den_in;
      end
   end

   // divider setup: magnitudes, rounding offset, overflow check
   logic [55:0] y2_mag, x2_mag;
   logic [pfp_pkg::NUM_W-1:0] ntd_ff, ntd_in, nnd_ff, nnd_in, dtop;
   logic [pfp_pkg::DEN_W-1:0] denp_ff;
   logic ntd_neg_in, nnd_neg_in, otd_in, ond_in;

   always_comb begin
      y2_mag     = y2_ff[55] ? unsigned'(-y2_ff) : unsigned'(y2_ff);
      x2_mag     = x2_ff[55] ? unsigned'(-x2_ff) : unsigned'(x2_ff);
      ntd_in     = pfp_pkg::NUM_W'({y2_mag, 1'b0}) + pfp_pkg::NUM_W'(den_ff >> 1);
      nnd_in     = pfp_pkg::NUM_W'({x2_mag, 1'b0}) + pfp_pkg::NUM_W'(den_ff >> 1);
      dtop       = pfp_pkg::NUM_W'(den_ff) << QB;
      otd_in     = ntd_in >= dtop;
      ond_in     = nnd_in >= dtop;
      ntd_neg_in = sneg_ff ^ y2_ff[55];
      nnd_neg_in = !(sneg_ff ^ x2_ff[55]);
   end

   // sign and overflow per lane, carried beside the divider
   logic [3:0] fl_ff [QB+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ntd_ff   <= ntd_in;
         nnd_ff   <= nnd_in;
         denp_ff  <= den_ff;
         fl_ff[0] <= {ntd_neg_in, otd_in, nnd_neg_in, ond_in};
         for (int i = 1; i <= QB; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   logic [QB-1:0] q_td, q_nd;

   pfp_divider u_div_td (
      .clock (clock),
      .en    (adv),
      .num   (ntd_ff),
      .den   (denp_ff),
      .quo   (q_td)
   );

   pfp_divider u_div_nd (
      .clock (clock),
      .en    (adv),
      .num   (nnd_ff),
      .den   (denp_ff),
      .quo   (q_nd)
   );

   // saturate and restore sign
   logic [QB-1:0] qs_td, qs_nd;
   logic [3:0]    fl;
   logic signed [18:0] td_ff, td_in, nd_ff, nd_in;

   always_comb begin
      fl    = fl_ff[QB];
      qs_td = (fl[2] || q_td > pfp_pkg::OUT_LIMIT) ? pfp_pkg::OUT_LIMIT : q_td;
      qs_nd = (fl[0] || q_nd > pfp_pkg::OUT_LIMIT) ? pfp_pkg::OUT_LIMIT : q_nd;
      td_in = fl[3] ? -signed'(19'(qs_td)) : signed'(19'(qs_td));
      nd_in = fl[1] ? -signed'(19'(qs_nd)) : signed'(19'(qs_nd));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         td_ff <= td_in;
         nd_ff <= nd_in;
      end
   end

   assign rsp_r_td = td_ff;
   assign rsp_r_nd = nd_ff;

   a_stall_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   a_td_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_r_td <= 19'sd131072 && rsp_r_td >= -19'sd131072)
      else $error("r_td beyond saturation limit");

   a_nd_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_r_nd <= 19'sd131072 && rsp_r_nd >= -19'sd131072)
      else $error("r_nd beyond saturation limit");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

/* rtl/pfp_cordic.sv */
module pfp_cordic (
   input  logic                clock,
   input  logic                en,
   input  logic signed [26:0]  angle,
   output logic signed [18:0]  cos_q16,
   output logic signed [18:0]  sin_q16
);

   logic signed [24:0] red_ff, red_in;
   logic signed [27:0] a_ext;

   logic signed [32:0] x_ff [pfp_pkg::CORDIC_STEPS+1];
   logic signed [32:0] y_ff [pfp_pkg::CORDIC_STEPS+1];
   logic signed [24:0] a_ff [pfp_pkg::CORDIC_STEPS+1];
   logic               neg_ff [pfp_pkg::CORDIC_STEPS+1];

   logic signed [24:0] fold_a;
   logic               fold_neg;
   logic signed [32:0] xr, yr, xs, ys;
   logic signed [18:0] cos_ff, cos_in, sin_ff, sin_in;

   // wrap into [-180, 180)
   always_comb begin
      a_ext = 28'(angle);
      if (a_ext >= pfp_pkg::DEG540) begin
         red_in = 25'(a_ext - (pfp_pkg::DEG360 <<< 1));
      end else if (a_ext >= pfp_pkg::DEG180) begin
         red_in = 25'(a_ext - pfp_pkg::DEG360);
      end else if (a_ext >= -pfp_pkg::DEG180) begin
         red_in = 25'(a_ext);
      end else if (a_ext >= -pfp_pkg::DEG540) begin
         red_in = 25'(a_ext + pfp_pkg::DEG360);
      end else begin
         red_in = 25'(a_ext + (pfp_pkg::DEG360 <<< 1));
      end
   end

   // fold into [-90, 90]
   always_comb begin
      fold_a   = red_ff;
      fold_neg = 1'b0;
      if (red_ff > pfp_pkg::DEG90) begin
         fold_a   = red_ff - pfp_pkg::DEG180_F;
         fold_neg = 1'b1;
      end else if (red_ff < -pfp_pkg::DEG90) begin
         fold_a   = red_ff + pfp_pkg::DEG180_F;
         fold_neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff    <= red_in;
         x_ff[0]   <= pfp_pkg::CORDIC_X0;
         y_ff[0]   <= '0;
         a_ff[0]   <= fold_a;
         neg_ff[0] <= fold_neg;
      end
   end

   for (genvar i = 0; i < pfp_pkg::CORDIC_STEPS; i++) begin : g_step
      logic signed [32:0] dx, dy;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (a_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dy;
               y_ff[i+1] <= y_ff[i] + dx;
               a_ff[i+1] <= a_ff[i] - pfp_pkg::ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + dy;
               y_ff[i+1] <= y_ff[i] - dx;
               a_ff[i+1] <= a_ff[i] + pfp_pkg::ATAN_TAB[i];
            end
         end
      end
   end

   // round to q16 and undo the fold
   always_comb begin
      xr = x_ff[pfp_pkg::CORDIC_STEPS] + 33'sd8192;
      yr = y_ff[pfp_pkg::CORDIC_STEPS] + 33'sd8192;
      xs = xr >>> 14;
      ys = yr >>> 14;
      cos_in = neg_ff[pfp_pkg::CORDIC_STEPS] ? 19'(-xs) : 19'(xs);
      sin_in = neg_ff[pfp_pkg::CORDIC_STEPS] ? 19'(-ys) : 19'(ys);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q16 = cos_ff;
   assign sin_q16 = sin_ff;

endmodule

/* rtl/pfp_divider.sv */
module pfp_divider (
   input  logic                           clock,
   input  logic                           en,
   input  logic [pfp_pkg::NUM_W-1:0]      num,
   input  logic [pfp_pkg::DEN_W-1:0]      den,
   output logic [pfp_pkg::QUO_BITS-1:0]   quo
);

   logic [pfp_pkg::NUM_W-1:0]    r_ff [pfp_pkg::QUO_BITS];
   logic [pfp_pkg::DEN_W-1:0]    d_ff [pfp_pkg::QUO_BITS];
   logic [pfp_pkg::QUO_BITS-1:0] q_ff [pfp_pkg::QUO_BITS];

   // restoring, one quotient bit per stage, msb first
   for (genvar k = 0; k < pfp_pkg::QUO_BITS; k++) begin : g_bit
      logic [pfp_pkg::NUM_W-1:0]    r_prev, dk;
      logic [pfp_pkg::DEN_W-1:0]    d_prev;
      logic [pfp_pkg::QUO_BITS-1:0] q_prev;
      if (k == 0) begin : g_first
         assign r_prev = num;
         assign d_prev = den;
         assign q_prev = '0;
      end else begin : g_rest
         assign r_prev = r_ff[k-1];
         assign d_prev = d_ff[k-1];
         assign q_prev = q_ff[k-1];
      end
      assign dk = pfp_pkg::NUM_W'(d_prev) << (pfp_pkg::QUO_BITS - 1 - k);
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= d_prev;
            if (r_prev >= dk) begin
               r_ff[k] <= r_prev - dk;
               q_ff[k] <= {q_prev[pfp_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
               r_ff[k] <= r_prev;
               q_ff[k] <= {q_prev[pfp_pkg::QUO_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = q_ff[pfp_pkg::QUO_BITS-1];

endmodule
